// ===== src/sslc_pkg.sv =====
// Shared types and codes for the sorted static linked list core.
`timescale 1ns / 1ps

package sslc_pkg;

  typedef enum logic [1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] key;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] slot;
    logic [6:0] count;
  } out_t;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic link_we;
  } store_ctl_t;

endpackage

// ===== src/sslc_store.sv =====
// Key and link memories with one registered read port and the untouched-slot link rule.
`timescale 1ns / 1ps

module sslc_store #(
  parameter int SLOTS = 64
) (
  input  logic                               clk,
  input  sslc_pkg::store_ctl_t               ctl,
  input  logic [$clog2(SLOTS)-1:0]           rd_addr,
  input  logic [$clog2(SLOTS+1)-1:0]         fill,
  input  logic [$clog2(SLOTS)-1:0]           key_waddr,
  input  logic signed [31:0]                 key_wdata,
  input  logic [$clog2(SLOTS)-1:0]           link_waddr,
  input  logic [$clog2(SLOTS+1)-1:0]         link_wdata,
  output logic signed [31:0]                 rd_key,
  output logic [$clog2(SLOTS+1)-1:0]         rd_link
);
  import sslc_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  logic signed [31:0] key_mem [SLOTS];
  logic [LW-1:0]      link_mem [SLOTS];

  logic signed [31:0] key_q;
  logic [LW-1:0]      link_q;
  logic [IW-1:0]      addr_q;
  logic               fresh_q;

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctl.rd_en) begin
      key_q   <= key_mem[rd_addr];
      link_q  <= link_mem[rd_addr];
      addr_q  <= rd_addr;
      fresh_q <= (LW'(rd_addr) >= fill);
    end
  end

  // A slot never allocated since reset or clear still links to the next slot.
  assign rd_key  = key_q;
  assign rd_link = fresh_q ? (LW'(addr_q) + LW'(1)) : link_q;

endmodule

// ===== src/sorted_static_linked_list_core.sv =====
// Top level of the sorted static linked list core: sequencer, list registers and result register.
`timescale 1ns / 1ps

// Usage: each beat on the input channel (in_valid/in_ready, payload in_data) asks for a
// search, insert, delete or clear on a sorted list of signed keys kept in SLOTS slots.
// Every input beat produces exactly one result beat on the output channel
// (out_valid/out_ready, payload out_data) with a status, a slot and the key count.
// Search, insert and delete walk the list through one memory read port, reading one link
// at a time in S_WALK and S_CMP; a walk visits at most SLOTS links. The next input beat
// can be taken once the result has moved into the output register. Clear and an insert
// into a full list skip the walk and go straight to the result.
// One item is worked on at a time; in_ready is high only while the sequencer is idle.
// A finished result sits in the output register until it is taken. If the receiver
// stalls with a result still held, the next item may be accepted and worked on, but its
// result is held, with the sequencer stalled, until the output register frees up.
// Reset empties the list and links every slot into the free list in ascending order.
// No clearing pass is needed: slots never allocated since reset or clear are tracked
// by a fill mark, so the block is ready as soon as reset is released.

module sorted_static_linked_list_core #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sslc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sslc_pkg::out_t out_data
);
  import sslc_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WALK = 8'b0000_0010,
    S_CMP  = 8'b0000_0100,
    S_DEC  = 8'b0000_1000,
    S_FRD  = 8'b0001_0000,
    S_FLNK = 8'b0010_0000,
    S_UPD1 = 8'b0100_0000,
    S_UPD2 = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic               fin_r, fin_nxt;
  func_t              func_r, func_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [LW-1:0]      cur_r, cur_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [LW-1:0]      steps_r, steps_nxt;
  logic               hit_r, hit_nxt;
  logic [LW-1:0]      cur_link_r, cur_link_nxt;
  logic [LW-1:0]      lhead_r, lhead_nxt;
  logic [LW-1:0]      fhead_r, fhead_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt;
  logic [LW-1:0]      fill_r, fill_nxt;
  status_t            status_r, status_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  store_ctl_t         ctl;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      key_waddr;
  logic [IW-1:0]      link_waddr;
  logic [LW-1:0]      link_wdata;
  logic signed [31:0] rd_key;
  logic [LW-1:0]      rd_link;

  logic cur_ok, prev_ok;

  assign cur_ok  = (cur_r < NONE);
  assign prev_ok = (prev_r < NONE);

  sslc_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .fill      (fill_r),
    .key_waddr (key_waddr),
    .key_wdata (key_r),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .rd_key    (rd_key),
    .rd_link   (rd_link)
  );

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    cur_link_nxt  = cur_link_r;
    lhead_nxt     = lhead_r;
    fhead_nxt     = fhead_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    rd_addr       = cur_r[IW-1:0];
    key_waddr     = fhead_r[IW-1:0];
    link_waddr    = prev_r[IW-1:0];
    link_wdata    = LW'(slot_r);

    if (fin_r) begin
      if (!out_valid_r || out_ready) begin
        out_data_nxt.status = status_r;
        out_data_nxt.slot   = 6'(slot_r);
        out_data_nxt.count  = 7'(cnt_r);
        out_valid_nxt       = 1'b1;
        fin_nxt             = 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_nxt   = in_data.func;
            key_nxt    = in_data.key;
            cur_nxt    = lhead_r;
            prev_nxt   = NONE;
            steps_nxt  = '0;
            hit_nxt    = 1'b0;
            status_nxt = ST_DONE;
            slot_nxt   = '0;
            case (in_data.func)
              FUNC_CLEAR: begin
                lhead_nxt = NONE;
                fhead_nxt = '0;
                cnt_nxt   = '0;
                fill_nxt  = '0;
                fin_nxt   = 1'b1;
              end
              FUNC_INSERT: begin
                if (fhead_r >= NONE) begin
                  status_nxt = ST_FULL;
                  fin_nxt    = 1'b1;
                end else begin
                  state_nxt = S_WALK;
                end
              end
              default: begin
                state_nxt = S_WALK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (cur_ok && (steps_r < NONE)) begin
            ctl.rd_en = 1'b1;
            state_nxt = S_CMP;
          end else begin
            cur_nxt   = NONE;
            hit_nxt   = 1'b0;
            state_nxt = S_DEC;
          end
        end
        S_CMP: begin
          if (rd_key < key_r) begin
            prev_nxt  = cur_r;
            cur_nxt   = rd_link;
            steps_nxt = steps_r + LW'(1);
            state_nxt = S_WALK;
          end else begin
            hit_nxt      = (rd_key == key_r);
            cur_link_nxt = rd_link;
            state_nxt    = S_DEC;
          end
        end
        S_DEC: begin
          case (func_r)
            FUNC_INSERT: begin
              if (hit_r) begin
                status_nxt = ST_DUPLICATE;
                fin_nxt    = 1'b1;
                state_nxt  = S_IDLE;
              end else begin
                state_nxt = S_FRD;
              end
            end
            FUNC_DELETE: begin
              if (hit_r) begin
                state_nxt = S_UPD1;
              end else begin
                status_nxt = ST_NOT_FOUND;
                fin_nxt    = 1'b1;
                state_nxt  = S_IDLE;
              end
            end
            default: begin
              if (hit_r) begin
                slot_nxt = cur_r[IW-1:0];
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
              fin_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
        S_FRD: begin
          ctl.rd_en = 1'b1;
          rd_addr   = fhead_r[IW-1:0];
          state_nxt = S_FLNK;
        end
        S_FLNK: begin
          ctl.key_we  = 1'b1;
          ctl.link_we = 1'b1;
          link_waddr  = fhead_r[IW-1:0];
          slot_nxt    = fhead_r[IW-1:0];
          fhead_nxt   = rd_link;
          cnt_nxt     = cnt_r + LW'(1);
          if (fhead_r >= fill_r) begin
            fill_nxt = fhead_r + LW'(1);
          end
          if (prev_ok) begin
            link_wdata = cur_r;
            state_nxt  = S_UPD1;
          end else begin
            link_wdata = lhead_r;
            lhead_nxt  = fhead_r;
            fin_nxt    = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
        S_UPD1: begin
          if (func_r == FUNC_INSERT) begin
            ctl.link_we = 1'b1;
            link_wdata  = LW'(slot_r);
            fin_nxt     = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            if (prev_ok) begin
              ctl.link_we = 1'b1;
              link_wdata  = cur_link_r;
            end else begin
              lhead_nxt = cur_link_r;
            end
            state_nxt = S_UPD2;
          end
        end
        S_UPD2: begin
          ctl.link_we = 1'b1;
          link_waddr  = cur_r[IW-1:0];
          link_wdata  = fhead_r;
          fhead_nxt   = cur_r;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - LW'(1);
          end
          slot_nxt  = cur_r[IW-1:0];
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      lhead_r     <= NONE;
      fhead_r     <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      lhead_r     <= lhead_nxt;
      fhead_r     <= fhead_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    hit_r      <= hit_nxt;
    cur_link_r <= cur_link_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE) && !fin_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/tb_sorted_static_linked_list_core.sv =====
// Testbench for the sorted static linked list core: directed and random list operations checked against a shadow list.
`timescale 1ns / 1ps

module tb_sorted_static_linked_list_core;
  import sslc_pkg::*;

  localparam int SLOTS = 64;
  localparam int LINK_NONE = SLOTS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  logic signed [31:0] shadow_key [SLOTS];
  int shadow_link [SLOTS];
  int shadow_head;
  int shadow_free;
  int shadow_count;

  out_t pending_results [$];
  int   errors;
  int   cycle_cnt;
  bit   idle_on;
  bit   hold_req;

  sorted_static_linked_list_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void shadow_reset();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_link[i] = i + 1;
    end
    shadow_link[SLOTS-1] = LINK_NONE;
    shadow_head = LINK_NONE;
    shadow_free = 0;
    shadow_count = 0;
  endfunction

  function automatic int link_of(int s);
    if (s < 0 || s >= SLOTS) return LINK_NONE;
    return (shadow_link[s] < SLOTS) ? shadow_link[s] : LINK_NONE;
  endfunction

  // Returns the first slot whose key is not below k; prev gets the slot before it.
  function automatic int walk_to(logic signed [31:0] k, output int prev);
    int cur;
    int steps;
    prev = LINK_NONE;
    cur = (shadow_head < SLOTS) ? shadow_head : LINK_NONE;
    steps = 0;
    while (cur < SLOTS && shadow_key[cur] < k && steps < SLOTS) begin
      prev = cur;
      cur = link_of(cur);
      steps++;
    end
    if (steps >= SLOTS) cur = LINK_NONE;
    return cur;
  endfunction

  function automatic out_t predict_list_op(in_t b);
    out_t r;
    int prev;
    int cur;
    int n;
    logic signed [31:0] k;
    k = $signed(b.key);
    r.status = ST_DONE;
    r.slot = '0;
    case (b.func)
      FUNC_SEARCH: begin
        cur = walk_to(k, prev);
        if (cur < SLOTS && shadow_key[cur] == k) r.slot = 6'(cur);
        else r.status = ST_NOT_FOUND;
      end
      FUNC_INSERT: begin
        if (shadow_free >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          cur = walk_to(k, prev);
          if (cur < SLOTS && shadow_key[cur] == k) begin
            r.status = ST_DUPLICATE;
          end else begin
            n = shadow_free;
            shadow_free = link_of(n);
            shadow_key[n] = k;
            if (prev < SLOTS) begin
              shadow_link[n] = link_of(prev);
              shadow_link[prev] = n;
            end else begin
              shadow_link[n] = (shadow_head < SLOTS) ? shadow_head : LINK_NONE;
              shadow_head = n;
            end
            shadow_count++;
            r.slot = 6'(n);
          end
        end
      end
      FUNC_DELETE: begin
        cur = walk_to(k, prev);
        if (cur >= SLOTS || shadow_key[cur] != k) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (prev < SLOTS) shadow_link[prev] = link_of(cur);
          else shadow_head = link_of(cur);
          shadow_link[cur] = (shadow_free < SLOTS) ? shadow_free : LINK_NONE;
          shadow_free = cur;
          if (shadow_count > 0) shadow_count--;
          r.slot = 6'(cur);
        end
      end
      default: shadow_reset();
    endcase
    r.count = 7'(shadow_count);
    return r;
  endfunction

  function automatic logic signed [31:0] near_key();
    logic signed [31:0] k;
    k = $urandom_range(0, 63);
    return k - 32;
  endfunction

  function automatic logic signed [31:0] wide_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7fff_ffff;
    return $urandom();
  endfunction

  function automatic logic signed [31:0] live_key();
    int idx;
    int cur;
    if (shadow_count == 0) return near_key();
    idx = $urandom_range(0, shadow_count - 1);
    cur = shadow_head;
    for (int i = 0; i < idx; i++) cur = link_of(cur);
    return shadow_key[cur];
  endfunction

  task automatic send_beat(input func_t f, input logic signed [31:0] k);
    in_t b;
    b.func = f;
    b.key = k;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_list_op(b));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d actual %0d",
                   $time, want.slot, out_data.slot);
          errors++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $time, want.count, out_data.count);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_empty_list();
    send_beat(FUNC_SEARCH, 32'sd0);
    send_beat(FUNC_DELETE, -32'sd1);
  endtask

  task automatic test_key_order();
    send_beat(FUNC_INSERT, 32'sd0);
    send_beat(FUNC_INSERT, 32'sh7fff_ffff);
    send_beat(FUNC_INSERT, 32'sh8000_0000);
    send_beat(FUNC_INSERT, -32'sd1);
    send_beat(FUNC_INSERT, 32'sd0);
    send_beat(FUNC_SEARCH, 32'sh8000_0000);
    send_beat(FUNC_SEARCH, 32'sh7fff_ffff);
    send_beat(FUNC_SEARCH, 32'sd5);
    send_beat(FUNC_DELETE, -32'sd1);
    send_beat(FUNC_DELETE, 32'sh8000_0000);
    send_beat(FUNC_DELETE, 32'sh7fff_ffff);
    send_beat(FUNC_DELETE, 32'sd12345);
    send_beat(FUNC_INSERT, 32'sd42);
    send_beat(FUNC_CLEAR, $urandom());
    send_beat(FUNC_SEARCH, 32'sd0);
    send_beat(FUNC_CLEAR, 32'sh7fff_ffff);
  endtask

  task automatic random_list_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_beat(FUNC_CLEAR, wide_key());
    else if (r < 40) begin
      r = $urandom_range(0, 3);
      send_beat(FUNC_INSERT, (r == 0) ? wide_key() : (r == 1) ? live_key() : near_key());
    end else if (r < 68) send_beat(FUNC_SEARCH, $urandom_range(0, 1) ? live_key() : near_key());
    else send_beat(FUNC_DELETE, ($urandom_range(0, 4) < 3) ? live_key() : near_key());
  endtask

  task automatic test_random_mix(input int items);
    for (int i = 0; i < items; i++) random_list_op();
  endtask

  task automatic test_full_list(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      send_beat(FUNC_CLEAR, wide_key());
      while (shadow_count < SLOTS) send_beat(FUNC_INSERT, wide_key());
      for (int i = 0; i < 6; i++)
        send_beat(FUNC_INSERT, $urandom_range(0, 1) ? live_key() : wide_key());
      for (int i = 0; i < 6; i++) send_beat(FUNC_SEARCH, live_key());
      for (int i = 0; i < 10; i++) send_beat(FUNC_DELETE, live_key());
      for (int i = 0; i < 10; i++) send_beat(FUNC_INSERT, wide_key());
      while (shadow_count > 0) begin
        if ($urandom_range(0, 9) == 0) send_beat(FUNC_DELETE, wide_key());
        else send_beat(FUNC_DELETE, live_key());
      end
    end
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) random_list_op();
  endtask

  task automatic test_noise(input int items);
    for (int i = 0; i < items; i++)
      send_beat(func_t'($urandom_range(0, 3)), wide_key());
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    shadow_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_empty_list();
    test_key_order();
    test_random_mix(700);
    test_full_list(3);
    test_output_backpressure();
    test_noise(300);
    idle_on = 1'b0;
    test_random_mix(200);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sslc_pkg.sv
src/sslc_store.sv
src/sorted_static_linked_list_core.sv
tb/sv/tb_sorted_static_linked_list_core.sv
